// File: rtl/core/srsw_pkg.sv
package srsw_pkg;

  typedef enum logic [1:0] {
    KIND_NEW,
    KIND_ACK,
    KIND_TMO,
    KIND_IGN
  } srsw_kind_t;

  localparam logic [1:0] OP_NEW = 2'd0;
  localparam logic [1:0] OP_ACK = 2'd1;
  localparam logic [1:0] OP_TMO = 2'd2;

  localparam logic [2:0] STATUS_SENT    = 3'd0;
  localparam logic [2:0] STATUS_FULL    = 3'd1;
  localparam logic [2:0] STATUS_ACK_OK  = 3'd2;
  localparam logic [2:0] STATUS_ACK_IGN = 3'd3;
  localparam logic [2:0] STATUS_RESENT  = 3'd4;

  localparam int unsigned KIND_W = 2;

endpackage

// File: rtl/core/selective_repeat_sender_window_core.sv
// selective repeat sender window
// command channel: present an event on the in_ ports with start high; it is
// taken at a rising edge where start is high and busy is low. in_operation
// selects new message, acknowledgment or timer expiry.
// result channel: every taken event gives one word, shown on the out_ ports
// for exactly one cycle while out_valid is high; nothing can hold it off.
// order: a new message, a plain ack or an ignored event gives its word
// straight from the idle state; a timer expiry passes the resend state (one
// memory read); an ack of the base stays in the slide state while the base
// slides past acked slots. events wait in a two-word queue; the executing stage
// takes one per cycle while idle and none while in the resend or slide state.
// busy is high while the queue is full.
// reset (rst_n low, synchronous) empties the queue, sets base and next
// sequence numbers to zero and clears all acked bits; stored payloads are
// kept and only a slot once sent is meaningful for a resend.
module selective_repeat_sender_window_core #(
  parameter int unsigned SEQ_SPACE    = 8,
  parameter int unsigned WINDOW_SIZE  = 4,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_payload_word,
  input  logic [2:0]  in_ack_number,
  input  logic        in_ack_checksum_ok,
  input  logic [2:0]  in_expired_seq,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_send_valid,
  output logic [2:0]  out_send_seq,
  output logic [63:0] out_send_payload,
  output logic        out_timer_start,
  output logic        out_timer_stop,
  output logic [2:0]  out_timer_seq,
  output logic [2:0]  out_window_base,
  output logic        out_window_full
);
  import srsw_pkg::*;

  localparam int unsigned SW  = $clog2(SEQ_SPACE);
  localparam int unsigned EFF = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : SEQ_SPACE - 1;
  localparam int unsigned QW  = KIND_W + SW + PAYLOAD_BITS;

  logic                    push;
  srsw_kind_t              f_kind;
  logic [SW-1:0]           f_seq;
  logic [PAYLOAD_BITS-1:0] f_payload;
  logic                    q_valid;
  logic                    q_full;
  logic [QW-1:0]           q_word;
  logic                    pop;
  srsw_kind_t              q_kind;

  assign busy   = q_full;
  assign q_kind = srsw_kind_t'(q_word[QW-1 -: KIND_W]);

  srsw_front #(
    .SEQ_SPACE (SEQ_SPACE),
    .SW        (SW),
    .PB        (PAYLOAD_BITS)
  ) u_front (
    .start              (start),
    .q_full             (q_full),
    .in_operation       (in_operation),
    .in_payload_word    (in_payload_word),
    .in_ack_number      (in_ack_number),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .in_expired_seq     (in_expired_seq),
    .push               (push),
    .kind               (f_kind),
    .seq                (f_seq),
    .payload            (f_payload)
  );

  srsw_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word ({f_kind, f_seq, f_payload}),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_word    (q_word)
  );

  srsw_back #(
    .SEQ_SPACE (SEQ_SPACE),
    .SW        (SW),
    .EFF       (EFF),
    .PB        (PAYLOAD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_kind           (q_kind),
    .q_seq            (q_word[PAYLOAD_BITS +: SW]),
    .q_payload        (q_word[PAYLOAD_BITS-1:0]),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_send_valid   (out_send_valid),
    .out_send_seq     (out_send_seq),
    .out_send_payload (out_send_payload),
    .out_timer_start  (out_timer_start),
    .out_timer_stop   (out_timer_stop),
    .out_timer_seq    (out_timer_seq),
    .out_window_base  (out_window_base),
    .out_window_full  (out_window_full)
  );

endmodule

// File: rtl/core/srsw_front.sv
module srsw_front #(
  parameter int unsigned SEQ_SPACE = 8,
  parameter int unsigned SW        = 3,
  parameter int unsigned PB        = 64
) (
  input  logic                  start,
  input  logic                  q_full,
  input  logic [1:0]            in_operation,
  input  logic [63:0]           in_payload_word,
  input  logic [2:0]            in_ack_number,
  input  logic                  in_ack_checksum_ok,
  input  logic [2:0]            in_expired_seq,
  output logic                  push,
  output srsw_pkg::srsw_kind_t  kind,
  output logic [SW-1:0]         seq,
  output logic [PB-1:0]         payload
);
  import srsw_pkg::*;

  localparam logic [8:0] SPACE9 = 9'(SEQ_SPACE);

  assign push    = start && !q_full;
  assign payload = in_payload_word[PB-1:0];

  always_comb begin
    logic [2:0] tmo;
    tmo = in_expired_seq;
    // reduce timeout number modulo the sequence space
    for (int i = 0; i < 4; i++) begin
      if ({6'd0, tmo} >= SPACE9) begin
        tmo = tmo - 3'(SEQ_SPACE);
      end
    end
    kind = KIND_IGN;
    seq  = '0;
    case (in_operation)
      OP_NEW: begin
        kind = KIND_NEW;
      end
      OP_ACK: begin
        if (in_ack_checksum_ok && ({6'd0, in_ack_number} < SPACE9)) begin
          kind = KIND_ACK;
          seq  = SW'(in_ack_number);
        end
      end
      OP_TMO: begin
        kind = KIND_TMO;
        seq  = SW'(tmo);
      end
      default: begin
        kind = KIND_IGN;
      end
    endcase
  end

endmodule

// File: rtl/core/srsw_queue.sv
module srsw_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_word,
  input  logic             pop,
  output logic             q_valid,
  output logic             q_full,
  output logic [WIDTH-1:0] q_word
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       count_r;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_word  = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule

// File: rtl/core/srsw_back.sv
module srsw_back #(
  parameter int unsigned SEQ_SPACE = 8,
  parameter int unsigned SW        = 3,
  parameter int unsigned EFF       = 4,
  parameter int unsigned PB        = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  srsw_pkg::srsw_kind_t  q_kind,
  input  logic [SW-1:0]         q_seq,
  input  logic [PB-1:0]         q_payload,
  output logic                  pop,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic                  out_send_valid,
  output logic [2:0]            out_send_seq,
  output logic [63:0]           out_send_payload,
  output logic                  out_timer_start,
  output logic                  out_timer_stop,
  output logic [2:0]            out_timer_seq,
  output logic [2:0]            out_window_base,
  output logic                  out_window_full
);
  import srsw_pkg::*;

  localparam logic [SW:0]   SPACE_W = (SW+1)'(SEQ_SPACE);
  localparam logic [SW:0]   EFF_W   = (SW+1)'(EFF);
  localparam logic [SW-1:0] LAST    = SW'(SEQ_SPACE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLIDE,
    S_RESEND
  } state_t;

  function automatic logic [SW:0] mod_diff(input logic [SW-1:0] a, input logic [SW-1:0] b);
    if (a >= b) begin
      return {1'b0, a} - {1'b0, b};
    end
    return {1'b0, a} + SPACE_W - {1'b0, b};
  endfunction

  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] a);
    return (a == LAST) ? '0 : a + 1'b1;
  endfunction

  state_t        state_r, state_nxt;
  logic [SW-1:0] base_r, base_nxt;
  logic [SW-1:0] next_r, next_nxt;
  logic [SEQ_SPACE-1:0] acked_r, acked_nxt;
  logic [SW-1:0] cmd_seq_r, cmd_seq_nxt;

  logic          valid_r, valid_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          send_valid_r, send_valid_nxt;
  logic [SW-1:0] send_seq_r, send_seq_nxt;
  logic [PB-1:0] send_payload_r, send_payload_nxt;
  logic          tstart_r, tstart_nxt;
  logic          tstop_r, tstop_nxt;
  logic [SW-1:0] tseq_r, tseq_nxt;
  logic [SW-1:0] wbase_r, wbase_nxt;
  logic          wfull_r, wfull_nxt;

  logic [PB-1:0] slot_mem_r [SEQ_SPACE];
  logic [PB-1:0] rd_data_r;
  logic          mem_we;
  logic          rd_en;
  logic [SW:0]   outst;
  logic [SW:0]   ack_off;

  assign outst   = mod_diff(next_r, base_r);
  assign ack_off = mod_diff(q_seq, base_r);

  always_comb begin
    state_nxt        = state_r;
    base_nxt         = base_r;
    next_nxt         = next_r;
    acked_nxt        = acked_r;
    cmd_seq_nxt      = cmd_seq_r;
    valid_nxt        = 1'b0;
    status_nxt       = STATUS_ACK_IGN;
    send_valid_nxt   = 1'b0;
    send_seq_nxt     = '0;
    send_payload_nxt = '0;
    tstart_nxt       = 1'b0;
    tstop_nxt        = 1'b0;
    tseq_nxt         = '0;
    wbase_nxt        = base_r;
    wfull_nxt        = (outst >= EFF_W);
    pop              = 1'b0;
    mem_we           = 1'b0;
    rd_en            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_kind)
            KIND_NEW: begin
              valid_nxt = 1'b1;
              if (outst >= EFF_W) begin
                status_nxt = STATUS_FULL;
              end else begin
                mem_we           = 1'b1;
                acked_nxt[next_r] = 1'b0;
                next_nxt         = seq_inc(next_r);
                status_nxt       = STATUS_SENT;
                send_valid_nxt   = 1'b1;
                send_seq_nxt     = next_r;
                send_payload_nxt = q_payload;
                tstart_nxt       = 1'b1;
                tseq_nxt         = next_r;
                wfull_nxt        = ((outst + 1'b1) >= EFF_W);
              end
            end
            KIND_ACK: begin
              if (ack_off < outst) begin
                acked_nxt[q_seq] = 1'b1;
                if (q_seq == base_r) begin
                  cmd_seq_nxt = q_seq;
                  state_nxt   = S_SLIDE;
                end else begin
                  valid_nxt  = 1'b1;
                  status_nxt = STATUS_ACK_OK;
                  tstop_nxt  = 1'b1;
                  tseq_nxt   = q_seq;
                end
              end else begin
                valid_nxt = 1'b1;
              end
            end
            KIND_TMO: begin
              rd_en       = 1'b1;
              cmd_seq_nxt = q_seq;
              state_nxt   = S_RESEND;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SLIDE: begin
        if ((base_r != next_r) && acked_r[base_r]) begin
          acked_nxt[base_r] = 1'b0;
          base_nxt          = seq_inc(base_r);
        end else begin
          valid_nxt  = 1'b1;
          status_nxt = STATUS_ACK_OK;
          tstop_nxt  = 1'b1;
          tseq_nxt   = cmd_seq_r;
          state_nxt  = S_IDLE;
        end
      end
      S_RESEND: begin
        valid_nxt        = 1'b1;
        status_nxt       = STATUS_RESENT;
        send_valid_nxt   = 1'b1;
        send_seq_nxt     = cmd_seq_r;
        send_payload_nxt = rd_data_r;
        tstart_nxt       = 1'b1;
        tseq_nxt         = cmd_seq_r;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[next_r] <= q_payload;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem_r[q_seq];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      base_r    <= '0;
      next_r    <= '0;
      acked_r   <= '0;
      cmd_seq_r <= '0;
      valid_r   <= 1'b0;
      status_r  <= STATUS_ACK_IGN;
      send_valid_r   <= 1'b0;
      send_seq_r     <= '0;
      send_payload_r <= '0;
      tstart_r  <= 1'b0;
      tstop_r   <= 1'b0;
      tseq_r    <= '0;
      wbase_r   <= '0;
      wfull_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      next_r    <= next_nxt;
      acked_r   <= acked_nxt;
      cmd_seq_r <= cmd_seq_nxt;
      valid_r   <= valid_nxt;
      status_r  <= status_nxt;
      send_valid_r   <= send_valid_nxt;
      send_seq_r     <= send_seq_nxt;
      send_payload_r <= send_payload_nxt;
      tstart_r  <= tstart_nxt;
      tstop_r   <= tstop_nxt;
      tseq_r    <= tseq_nxt;
      wbase_r   <= wbase_nxt;
      wfull_r   <= wfull_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_send_valid   = send_valid_r;
  assign out_send_seq     = 3'(send_seq_r);
  assign out_send_payload = 64'(send_payload_r);
  assign out_timer_start  = tstart_r;
  assign out_timer_stop   = tstop_r;
  assign out_timer_seq    = 3'(tseq_r);
  assign out_window_base  = 3'(wbase_r);
  assign out_window_full  = wfull_r;

  a_send_with_timer: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (send_valid_r == tstart_r)) else $error("send without timer start");
  a_stop_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    tstop_r |-> !send_valid_r) else $error("timer stop with a send");
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outst <= EFF_W) else $error("outstanding count beyond window");
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (status_r == STATUS_FULL)) |-> wfull_r) else $error("refused while not full");

endmodule
